### design/sorted_table_insert_search_assert.svh
// ----------------------------------------------------------------------------
// sorted table assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define STIS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define STIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/stis_pkg.sv
// ----------------------------------------------------------------------------
// stis_pkg
// shared constants, codes and types of the sorted table block
// ----------------------------------------------------------------------------
package stis_pkg;

   // default table depth
   localparam int DEFAULT_DEPTH = 64;

   // field widths
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 6;
   localparam int STAT_W  = 2;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd2;

   // response status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

   // search unit result
   typedef struct packed {
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } srch_res_type;

endpackage

### design/stis_cell.sv
// ----------------------------------------------------------------------------
// stis_cell
// one table slot: holds an entry, compares it against the key and takes
// either its left neighbor's entry or the key on an insert
// ----------------------------------------------------------------------------
module stis_cell (
   input  logic                                clock,
   input  logic                                shift_en,
   input  logic                                valid,
   input  logic                                tail,
   input  logic                                left_gt,
   input  logic signed [stis_pkg::VALUE_W-1:0] left_value,
   input  logic signed [stis_pkg::VALUE_W-1:0] key,
   output logic signed [stis_pkg::VALUE_W-1:0] value,
   output logic                                gt,
   output logic                                eq,
   output logic                                lt
);
   import stis_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // compare flags, greater-than only counts for a filled slot
   assign gt    = valid && (value_ff > key);
   assign eq    = (value_ff == key);
   assign lt    = (value_ff < key);
   assign value = value_ff;

   // shift up from the left while the left entry is greater, else take the key
   always_comb begin
      value_in = value_ff;
      if (shift_en && (gt || tail)) begin
         value_in = left_gt ? left_value : key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/stis_search.sv
// ----------------------------------------------------------------------------
// stis_search
// bisection sequencer over the compare flags captured from the cell row
// ----------------------------------------------------------------------------
module stis_search #(
   parameter int DEPTH = stis_pkg::DEFAULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [$clog2(DEPTH+1)-1:0] count,
   input  logic [DEPTH-1:0]           eq_vec,
   input  logic [DEPTH-1:0]           lt_vec,
   output logic                       busy,
   output stis_pkg::srch_res_type     res
);
   import stis_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SW     = CNT_W + 1;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIDE_W = SW + POS_W;

   logic                 busy_ff, busy_in;
   logic signed [SW-1:0] lo_ff, lo_in;
   logic signed [SW-1:0] hi_ff, hi_in;
   logic [DEPTH-1:0]     eq_ff, eq_in;
   logic [DEPTH-1:0]     lt_ff, lt_in;

   logic signed [SW-1:0] mid;
   logic [IDX_W-1:0]     mid_idx;
   logic [WIDE_W-1:0]    mid_ext;
   logic                 in_range;
   logic                 hit;

   // midpoint of the live window
   assign mid      = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign mid_idx  = mid[IDX_W-1:0];
   assign mid_ext  = WIDE_W'(unsigned'(mid));
   assign in_range = (lo_ff <= hi_ff);
   assign hit      = in_range && eq_ff[mid_idx];

   assign busy         = busy_ff;
   assign res.done     = busy_ff && (!in_range || hit);
   assign res.found    = busy_ff && hit;
   assign res.position = hit ? mid_ext[POS_W-1:0] : '0;

   // one bisection step per cycle
   always_comb begin
      busy_in = busy_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      eq_in   = eq_ff;
      lt_in   = lt_ff;
      if (start) begin
         busy_in = 1'b1;
         lo_in   = '0;
         hi_in   = signed'({1'b0, count}) - SW'(1);
         eq_in   = eq_vec;
         lt_in   = lt_vec;
      end else if (busy_ff) begin
         if (!in_range || hit) begin
            busy_in = 1'b0;
         end else if (lt_ff[mid_idx]) begin
            lo_in = mid + SW'(1);
         end else begin
            hi_in = mid - SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      eq_ff <= eq_in;
      lt_ff <= lt_in;
   end

endmodule

### design/sorted_table_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// ascending table of signed values with insert, bisection search and clear
// ----------------------------------------------------------------------------
// usage
//  - request beats come in on req_*: req_tuser is the kind (insert, search,
//    clear), req_tdata the signed value or search key
//  - every request gives exactly one response beat on rsp_*: rsp_tuser is
//    the status (ok/found, not present, full), rsp_tdata the match position
//  - insert and clear finish in the accept cycle; the response is registered
//    and shows in the next cycle, so they run at one request every cycle
//    while the receiver keeps rsp_tready high
//  - a search captures the compare flags of all slots in the accept cycle
//    and then walks the bisection one step a cycle in the search unit; its
//    result is registered on the response side, and no request is taken
//    meanwhile
//  - one result register sits on the response side; a new request is taken
//    while it is empty or being drained in the same cycle
//  - when the receiver stalls, the response holds and req_tready drops
//  - reset empties the table (count to zero) and drops any pending response;
//    slot contents are not cleared and are never read before written
// ----------------------------------------------------------------------------
module sorted_table_insert_search #(
   parameter int DEPTH = stis_pkg::DEFAULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0] req_tuser,    // [1:0] req_type
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [5:0] position, [7:6] zero
   output logic [1:0] rsp_tuser     // [1:0] status
);
   import stis_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;

   logic                     req_beat;
   logic                     full;
   logic                     do_insert;
   logic                     do_search;
   logic                     srch_busy;
   srch_res_type             srch_res;
   logic signed [VALUE_W-1:0] key;

   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]          cell_gt;
   logic [DEPTH-1:0]          cell_eq;
   logic [DEPTH-1:0]          cell_lt;

   // request handshake
   assign req_tready = !srch_busy && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;
   assign key        = signed'(req_tdata);
   assign full       = (count_ff >= CNT_W'(DEPTH));
   assign do_insert  = req_beat && (req_tuser == REQ_INSERT) && !full;
   assign do_search  = req_beat && (req_tuser == REQ_SEARCH);

   // row of table cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      left_gt;
      logic signed [VALUE_W-1:0] left_value;
      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_value = key;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
      end
      stis_cell u_cell (
         .clock      (clock),
         .shift_en   (do_insert),
         .valid      (CNT_W'(i) < count_ff),
         .tail       (CNT_W'(i) == count_ff),
         .left_gt    (left_gt),
         .left_value (left_value),
         .key        (key),
         .value      (cell_value[i]),
         .gt         (cell_gt[i]),
         .eq         (cell_eq[i]),
         .lt         (cell_lt[i])
      );
   end

   // bisection over the captured flags
   stis_search #(
      .DEPTH (DEPTH)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (do_search),
      .count  (count_ff),
      .eq_vec (cell_eq),
      .lt_vec (cell_lt),
      .busy   (srch_busy),
      .res    (srch_res)
   );

   // fill count
   always_comb begin
      count_in = count_ff;
      if (req_beat && (req_tuser == REQ_CLEAR)) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (srch_res.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = srch_res.found ? ST_OK : ST_ABSENT;
         rsp_pos_in    = srch_res.position;
      end else if (req_beat && !do_search) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ((req_tuser == REQ_INSERT) && full) ? ST_FULL : ST_OK;
         rsp_pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### design/stis_checker.sv
// ----------------------------------------------------------------------------
// stis_checker
// port-level checks of the sorted table block, bound to its top level
// ----------------------------------------------------------------------------
`include "sorted_table_insert_search_assert.svh"

module stis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import stis_pkg::*;

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // stalled response beat holds
   `STIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // status is one of the three defined codes
   `STIS_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_ABSENT || rsp_tuser == ST_FULL, "undefined status code")

   // position is zero unless status is ok
   `STIS_ASSERT_NOW(a_pos_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == 8'd0, "nonzero position without a match")

   // insert, clear and unused kinds answer on the next cycle
   `STIS_ASSERT_NEXT(a_fast_rsp, clock, reset, req_beat && req_tuser != REQ_SEARCH, rsp_tvalid, "missing response after a one-cycle request")

endmodule

bind sorted_table_insert_search stis_checker u_stis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### verif/sorted_table_insert_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search_test
// Self-checking bench for the sorted table block. A driver sends insert,
// search, clear and unused-code beats from a queue. A shadow copy of the
// table predicts each response when its request is accepted. A monitor
// compares every response beat with the oldest prediction. The run goes
// through phases with and without random idling on either side. Each phase
// fills the table past full.
// ----------------------------------------------------------------------------
module sorted_table_insert_search_test;
   import stis_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      bit                 wait_idle;   // hold off until every response is back
   } table_req_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
   } table_outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;    // [31:0] value
   logic [1:0]        req_tuser = '0;    // [1:0] req_type
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [5:0] position, [7:6] zero
   logic [1:0]        rsp_tuser;         // [1:0] status

   table_req_type     request_q[$];
   table_outcome_type outcome_q[$];
   int                n_accepted = 0;
   int                n_checked = 0;
   int                error_count = 0;
   int                idle_cycles = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;

   // shadow table, signed ascending
   logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
   int                        sorted_count = 0;

   // values the generator believes are stored, for picking hit keys
   logic [VALUE_W-1:0] stored_guess[$];

   sorted_table_insert_search #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock generation
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch %0d at %0t: %s", error_count, $realtime, msg);
   endtask

   // apply one request to the shadow table and return its response
   function automatic table_outcome_type apply_table_op(input logic [KIND_W-1:0] kind,
                                                         input logic [VALUE_W-1:0] raw);
      table_outcome_type       res;
      logic signed [VALUE_W-1:0] key;
      int                      slot;
      int                      lo;
      int                      hi;
      int                      mid;
      bit                      hit;
      res.status = ST_OK;
      res.position = '0;
      key = raw;
      case (kind)
         REQ_INSERT: begin
            if (sorted_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // shift greater entries up, new value lands after its equals
               slot = sorted_count;
               while (slot > 0 && sorted_vals[slot-1] > key) begin
                  sorted_vals[slot] = sorted_vals[slot-1];
                  slot--;
               end
               sorted_vals[slot] = key;
               sorted_count++;
            end
         end
         REQ_SEARCH: begin
            // bisection, first probe that matches wins
            lo = 0;
            hi = sorted_count - 1;
            hit = 1'b0;
            while (lo <= hi && !hit) begin
               mid = lo + (hi - lo) / 2;
               if (sorted_vals[mid] == key) begin
                  hit = 1'b1;
                  res.position = mid[POS_W-1:0];
               end else if (sorted_vals[mid] < key) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            if (!hit) res.status = ST_ABSENT;
         end
         REQ_CLEAR: begin
            sorted_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      table_req_type nxt;
      bit            fired;
      fired = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fired) begin
            outcome_q.push_back(apply_table_op(req_tuser, req_tdata));
            n_accepted <= n_accepted + 1;
         end
         if (!req_tvalid || fired) begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(request_q[0].wait_idle && (fired || n_accepted != n_checked))) begin
               nxt = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tuser  <= nxt.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      table_outcome_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_checked <= n_checked + 1;
            if (outcome_q.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               exp_res = outcome_q.pop_front();
               if (rsp_tuser !== exp_res.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, exp_res.status));
               if (rsp_tdata !== {2'b00, exp_res.position})
                  report_mismatch($sformatf("tdata 0x%02h, expected 0x%02h",
                                            rsp_tdata, {2'b00, exp_res.position}));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                            input bit wait_idle = 1'b0);
      table_req_type r;
      r.kind = kind;
      r.value = value;
      r.wait_idle = wait_idle;
      request_q.push_back(r);
      if (kind == REQ_CLEAR) stored_guess.delete();
      else if (kind == REQ_INSERT && stored_guess.size() < DEPTH) stored_guess.push_back(value);
   endtask

   // clustered or extreme values in just over half the picks so that duplicates and hits are common
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 16) - 8;
      if (r < 52) begin
         case ($urandom_range(0, 5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_MIN + 1;
            3: return VAL_MAX - 1;
            4: return '1;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_key();
      if (stored_guess.size() > 0 && $urandom_range(0, 99) < 60)
         return stored_guess[$urandom_range(0, stored_guess.size() - 1)];
      return pick_value();
   endfunction

   task automatic wait_drained();
      while (request_q.size() > 0 || req_tvalid || n_accepted != n_checked)
         @(negedge clock);
   endtask

   task automatic run_phase(input int send_idle, input int recv_stall);
      int r;
      wait_drained();
      send_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      // random mix
      repeat (70) begin
         r = $urandom_range(0, 99);
         if (r < 52)      queue_req(REQ_INSERT, pick_value());
         else if (r < 96) queue_req(REQ_SEARCH, pick_key());
         else if (r < 98) queue_req(REQ_CLEAR, $urandom);
         else             queue_req(REQ_UNUSED, $urandom);
      end
      // fill past full with searches along the way; sender drains first
      queue_req(REQ_CLEAR, $urandom, 1'b1);
      for (int i = 0; i < DEPTH + 4; i++) begin
         queue_req(REQ_INSERT, pick_value());
         if (i % 6 == 5) queue_req(REQ_SEARCH, pick_key());
      end
      repeat (6) queue_req(REQ_SEARCH, pick_key());
      queue_req(REQ_SEARCH, $urandom);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty search, extremes, duplicates, unused code, stale after clear
      queue_req(REQ_SEARCH, '0);
      queue_req(REQ_INSERT, VAL_MAX);
      queue_req(REQ_INSERT, VAL_MIN);
      queue_req(REQ_INSERT, '0);
      queue_req(REQ_INSERT, '1);
      queue_req(REQ_INSERT, '0);
      queue_req(REQ_INSERT, 32'd1);
      queue_req(REQ_SEARCH, VAL_MIN);
      queue_req(REQ_SEARCH, VAL_MAX);
      queue_req(REQ_SEARCH, '0);
      queue_req(REQ_SEARCH, '1);
      queue_req(REQ_SEARCH, 32'd5);
      queue_req(REQ_SEARCH, 32'd1);
      queue_req(REQ_UNUSED, '1);
      queue_req(REQ_SEARCH, VAL_MAX);
      queue_req(REQ_CLEAR, '0);
      queue_req(REQ_SEARCH, '0);
      queue_req(REQ_INSERT, 32'd7);
      queue_req(REQ_SEARCH, 32'd7);
      queue_req(REQ_INSERT, '1);
      queue_req(REQ_INSERT, '1);
      queue_req(REQ_SEARCH, '1);
      queue_req(REQ_SEARCH, VAL_MIN);

      run_phase(0, 0);
      run_phase(47, 0);
      run_phase(0, 47);
      run_phase(36, 36);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", outcome_q.size()));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sorted_table_insert_search.f
+incdir+design
design/stis_pkg.sv
design/stis_cell.sv
design/stis_search.sv
design/sorted_table_insert_search.sv
design/stis_checker.sv
verif/sorted_table_insert_search_test.sv
